// ===== rtl/grds_pkg.sv =====
`timescale 1ns / 1ps
// Package with the shared widths, register indexes and result record of the domain segmenter.
package grds_pkg;

   localparam int CHROM_W    = 16;
   localparam int POS_W      = 32;
   localparam int END_W      = 33;
   localparam int COUNT_W    = 16;
   localparam int SITES_W    = 24;
   localparam int SCORE_W    = 40;
   localparam int NUMBER_W   = 24;
   localparam int REPS_W     = 3;
   localparam int REP_FIELDS = 4;

   typedef enum logic [0:0] {
      CSR_GAP_LIMIT       = 1'b0,
      CSR_REPLICATE_COUNT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [CHROM_W-1:0]  domain_chrom;
      logic [POS_W-1:0]    start_position;
      logic [END_W-1:0]    end_position;
      logic [SITES_W-1:0]  site_count;
      logic [SCORE_W-1:0]  domain_score;
      logic [NUMBER_W-1:0] domain_number;
   } result_type;

endpackage

// ===== rtl/grds_if.sv =====
`timescale 1ns / 1ps
// Channel interfaces for site beats and domain beats.
interface grds_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] chrom_id;
   logic [31:0] position;
   logic        domain_bit;
   logic [15:0] meth_count_0;
   logic [15:0] unmeth_count_0;
   logic [15:0] meth_count_1;
   logic [15:0] unmeth_count_1;
   logic [15:0] meth_count_2;
   logic [15:0] unmeth_count_2;
   logic [15:0] meth_count_3;
   logic [15:0] unmeth_count_3;
   logic        end_of_stream;
   modport source (output valid, chrom_id, position, domain_bit, meth_count_0,
      unmeth_count_0, meth_count_1, unmeth_count_1, meth_count_2, unmeth_count_2,
      meth_count_3, unmeth_count_3, end_of_stream, input ready);
   modport sink (input valid, chrom_id, position, domain_bit, meth_count_0,
      unmeth_count_0, meth_count_1, unmeth_count_1, meth_count_2, unmeth_count_2,
      meth_count_3, unmeth_count_3, end_of_stream, output ready);
endinterface

interface grds_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] domain_chrom;
   logic [31:0] start_position;
   logic [32:0] end_position;
   logic [23:0] site_count;
   logic [39:0] domain_score;
   logic [23:0] domain_number;
   modport source (output valid, domain_chrom, start_position, end_position, site_count,
      domain_score, domain_number, input ready);
   modport sink (input valid, domain_chrom, start_position, end_position, site_count,
      domain_score, domain_number, output ready);
endinterface

// ===== rtl/grds_lane.sv =====
`timescale 1ns / 1ps
// Replicate lane: restoring divider of unmeth*2^F/(meth+unmeth), one bit a cycle on step.
module grds_lane
   import grds_pkg::*;
#(
   parameter int FRACTION_BITS = 16
) (
   input  logic                     clock,
   input  logic                     start,
   input  logic                     step,
   input  logic [COUNT_W-1:0]       meth_count,
   input  logic [COUNT_W-1:0]       unmeth_count,
   output logic [FRACTION_BITS:0]   quotient
);

   logic [COUNT_W+1:0]    rem_ff, rem_in;
   logic [COUNT_W:0]      total_ff;
   logic [FRACTION_BITS:0] quot_ff, quot_in;
   logic [COUNT_W+1:0]    diff;
   logic                  fits;

   always_comb begin
      fits    = rem_ff >= {1'b0, total_ff};
      diff    = rem_ff - {1'b0, total_ff};
      rem_in  = fits ? {diff[COUNT_W:0], 1'b0} : {rem_ff[COUNT_W:0], 1'b0};
      quot_in = {quot_ff[FRACTION_BITS-1:0], fits};
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff   <= {2'b00, unmeth_count};
         total_ff <= {1'b0, meth_count} + {1'b0, unmeth_count};
         quot_ff  <= '0;
      end else if (step) begin
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
      end
   end

   assign quotient = quot_ff;

endmodule

// ===== rtl/grds_run.sv =====
`timescale 1ns / 1ps
// Merge stage: region breaks, domain run state and result record on each close.
module grds_run
   import grds_pkg::*;
#(
   parameter int SITE_W = 19
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               commit,
   input  logic               end_of_stream,
   input  logic [CHROM_W-1:0] chrom_id,
   input  logic [POS_W-1:0]   position,
   input  logic               domain_bit,
   input  logic [POS_W-1:0]   gap_limit,
   input  logic [SITE_W-1:0]  site_score,
   output logic               emit,
   output result_type         result
);

   logic                have_prev_ff, have_prev_in;
   logic [CHROM_W-1:0]  prev_chrom_ff, prev_chrom_in;
   logic [POS_W-1:0]    prev_pos_ff, prev_pos_in;
   logic                open_ff, open_in;
   logic [CHROM_W-1:0]  run_chrom_ff, run_chrom_in;
   logic [POS_W-1:0]    run_start_ff, run_start_in;
   logic [SITES_W-1:0]  run_sites_ff, run_sites_in;
   logic [SCORE_W-1:0]  run_score_ff, run_score_in;
   logic [NUMBER_W-1:0] counter_ff, counter_in;
   logic                brk;
   logic [POS_W-1:0]    gap;
   logic [SCORE_W:0]    score_sum;

   always_comb begin
      gap       = position - prev_pos_ff;
      brk       = !have_prev_ff || (chrom_id != prev_chrom_ff) ||
                  (position < prev_pos_ff) || (gap > gap_limit);
      score_sum = {1'b0, run_score_ff} + (SCORE_W + 1)'(site_score);
      emit      = open_ff && (end_of_stream || brk || !domain_bit);

      result.domain_chrom   = run_chrom_ff;
      result.start_position = run_start_ff;
      result.end_position   = {1'b0, prev_pos_ff} + 33'd1;
      result.site_count     = run_sites_ff;
      result.domain_score   = run_score_ff;
      result.domain_number  = counter_ff;

      have_prev_in  = have_prev_ff;
      prev_chrom_in = prev_chrom_ff;
      prev_pos_in   = prev_pos_ff;
      open_in       = open_ff;
      run_chrom_in  = run_chrom_ff;
      run_start_in  = run_start_ff;
      run_sites_in  = run_sites_ff;
      run_score_in  = run_score_ff;
      counter_in    = emit ? counter_ff + 1'b1 : counter_ff;

      if (end_of_stream) begin
         open_in      = 1'b0;
         have_prev_in = 1'b0;
      end else begin
         have_prev_in  = 1'b1;
         prev_chrom_in = chrom_id;
         prev_pos_in   = position;
         if (domain_bit) begin
            open_in = 1'b1;
            if (!open_ff || brk) begin
               run_chrom_in = chrom_id;
               run_start_in = position;
               run_sites_in = SITES_W'(1);
               run_score_in = SCORE_W'(site_score);
            end else begin
               if (run_sites_ff != '1) begin
                  run_sites_in = run_sites_ff + 1'b1;
               end
               run_score_in = score_sum[SCORE_W] ? '1 : score_sum[SCORE_W-1:0];
            end
         end else begin
            open_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff  <= 1'b0;
         prev_chrom_ff <= '0;
         prev_pos_ff   <= '0;
         open_ff       <= 1'b0;
         run_chrom_ff  <= '0;
         run_start_ff  <= '0;
         run_sites_ff  <= '0;
         run_score_ff  <= '0;
         counter_ff    <= '0;
      end else if (commit) begin
         have_prev_ff  <= have_prev_in;
         prev_chrom_ff <= prev_chrom_in;
         prev_pos_ff   <= prev_pos_in;
         open_ff       <= open_in;
         run_chrom_ff  <= run_chrom_in;
         run_start_ff  <= run_start_in;
         run_sites_ff  <= run_sites_in;
         run_score_ff  <= run_score_in;
         counter_ff    <= counter_in;
      end
   end

endmodule

// ===== rtl/genomic_run_domain_segmenter_top.sv =====
`timescale 1ns / 1ps
// Top level of the genomic run domain segmenter: control, replicate lanes and output register.
//
//   channel | dir | carries
//   req     | in  | one site beat or an end-of-stream beat
//   rsp     | out | one closed domain beat
//   csr     | in  | gap limit (index 0), replicate_count (index 1)
//
// A kept site is loaded into the replicate lanes, runs through their bit-serial dividers,
// has the lane quotients added in ST_SUM and is committed in ST_COMMIT. Dropped sites
// skip the lanes and the commit; end-of-stream beats go straight from ST_IDLE to ST_COMMIT.
// Reset is synchronous and clears all run state and the output valid flag.
// A waiting output beat holds the commit step, and the input stays stalled until it is taken.
module genomic_run_domain_segmenter_top
   import grds_pkg::*;
#(
   parameter int MAX_REPLICATES = 4,
   parameter int FRACTION_BITS  = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [0:0]        csr_index,
   input  logic [POS_W-1:0]  csr_write_data,
   grds_req_if.sink          req_chan,
   grds_rsp_if.source        rsp_chan
);

   localparam int SITE_W = FRACTION_BITS + 3;
   localparam int STEP_W = $clog2(FRACTION_BITS + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_SUM, ST_COMMIT} state_type;

   state_type             state_ff;
   logic [STEP_W-1:0]     step_ff;
   logic [POS_W-1:0]      desert_ff;
   logic [REPS_W-1:0]     reps_ff;
   logic [REPS_W-1:0]     reps_eff;
   logic [CHROM_W-1:0]    chrom_ff;
   logic [POS_W-1:0]      pos_ff;
   logic                  dom_ff;
   logic                  eos_ff;
   logic [SITE_W-1:0]     site_ff, site_in;
   logic                  rsp_valid_ff;
   result_type            rsp_data_ff;
   logic [COUNT_W-1:0]    meth_in   [REP_FIELDS];
   logic [COUNT_W-1:0]    unmeth_in [REP_FIELDS];
   logic [FRACTION_BITS:0] quot [MAX_REPLICATES];
   logic                  accept, drop, start, commit_go, emit;
   result_type            result;

   assign meth_in[0]   = req_chan.meth_count_0;
   assign meth_in[1]   = req_chan.meth_count_1;
   assign meth_in[2]   = req_chan.meth_count_2;
   assign meth_in[3]   = req_chan.meth_count_3;
   assign unmeth_in[0] = req_chan.unmeth_count_0;
   assign unmeth_in[1] = req_chan.unmeth_count_1;
   assign unmeth_in[2] = req_chan.unmeth_count_2;
   assign unmeth_in[3] = req_chan.unmeth_count_3;

   always_comb begin
      if (reps_ff == '0) begin
         reps_eff = REPS_W'(1);
      end else if (reps_ff > REPS_W'(MAX_REPLICATES)) begin
         reps_eff = REPS_W'(MAX_REPLICATES);
      end else begin
         reps_eff = reps_ff;
      end
      drop = 1'b0;
      for (int r = 0; r < MAX_REPLICATES; r++) begin
         if ((REPS_W'(r) < reps_eff) && (meth_in[r] == '0) && (unmeth_in[r] == '0)) begin
            drop = 1'b1;
         end
      end
      site_in = '0;
      for (int r = 0; r < MAX_REPLICATES; r++) begin
         if (REPS_W'(r) < reps_eff) begin
            site_in = site_in + SITE_W'(quot[r]);
         end
      end
   end

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept    = req_chan.valid && req_chan.ready;
   assign start     = accept && !req_chan.end_of_stream && !drop;
   assign commit_go = (state_ff == ST_COMMIT) && !(rsp_valid_ff && !rsp_chan.ready);

   for (genvar g = 0; g < MAX_REPLICATES; g++) begin : g_lane
      grds_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane (
         .clock        (clock),
         .start        (start),
         .step         (state_ff == ST_DIV),
         .meth_count   (meth_in[g]),
         .unmeth_count (unmeth_in[g]),
         .quotient     (quot[g])
      );
   end

   grds_run #(.SITE_W(SITE_W)) u_run (
      .clock         (clock),
      .reset         (reset),
      .commit        (commit_go),
      .end_of_stream (eos_ff),
      .chrom_id      (chrom_ff),
      .position      (pos_ff),
      .domain_bit    (dom_ff),
      .gap_limit     (desert_ff),
      .site_score    (site_ff),
      .emit          (emit),
      .result        (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         desert_ff    <= POS_W'(1000);
         reps_ff      <= REPS_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_GAP_LIMIT:       desert_ff <= csr_write_data;
               CSR_REPLICATE_COUNT: reps_ff   <= csr_write_data[REPS_W-1:0];
               default:             desert_ff <= desert_ff;
            endcase
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept && req_chan.end_of_stream) begin
                  state_ff <= ST_COMMIT;
               end else if (start) begin
                  state_ff <= ST_DIV;
                  step_ff  <= '0;
               end
            end
            ST_DIV: begin
               if (step_ff == STEP_W'(FRACTION_BITS)) begin
                  state_ff <= ST_SUM;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_SUM:    state_ff <= ST_COMMIT;
            ST_COMMIT: begin
               if (commit_go) begin
                  state_ff <= ST_IDLE;
               end
            end
            default:   state_ff <= ST_IDLE;
         endcase
         if (commit_go && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         chrom_ff <= req_chan.chrom_id;
         pos_ff   <= req_chan.position;
         dom_ff   <= req_chan.domain_bit;
         eos_ff   <= req_chan.end_of_stream;
      end
      if (state_ff == ST_SUM) begin
         site_ff <= site_in;
      end
      if (commit_go && emit) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.domain_chrom   = rsp_data_ff.domain_chrom;
   assign rsp_chan.start_position = rsp_data_ff.start_position;
   assign rsp_chan.end_position   = rsp_data_ff.end_position;
   assign rsp_chan.site_count     = rsp_data_ff.site_count;
   assign rsp_chan.domain_score   = rsp_data_ff.domain_score;
   assign rsp_chan.domain_number  = rsp_data_ff.domain_number;

   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_COMMIT))
      else $error("Output beat appeared without a commit.");

   a_site_starts_div: assert property (@(posedge clock) disable iff (reset)
      start |=> (state_ff == ST_DIV) && (step_ff == '0))
      else $error("Kept site did not start the lanes.");

   a_div_leads_to_sum: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) && (step_ff == STEP_W'(FRACTION_BITS)) |=> (state_ff == ST_SUM))
      else $error("Division did not finish after all quotient bits.");

   a_no_commit_when_blocked: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT) && rsp_valid_ff && !rsp_chan.ready |=> (state_ff == ST_COMMIT))
      else $error("Commit taken while the output beat was blocked.");

endmodule

// ===== verif/tb_genomic_run_domain_segmenter_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the genomic run domain segmenter: directed and random site beats.
module tb_genomic_run_domain_segmenter_top;
   import grds_pkg::*;

   localparam int FRAC = 16;
   localparam int MAXREP = 4;
   localparam int WATCHDOG_LIMIT = 200000;
   localparam logic [SITES_W-1:0] SITES_SAT = '1;
   localparam logic [SCORE_W-1:0] SCORE_SAT = '1;

   typedef struct {
      logic [15:0] chrom;
      logic [31:0] pos;
      logic        dom;
      logic [15:0] meth [4];
      logic [15:0] unmeth [4];
      logic        eos;
   } site_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [0:0] csr_index = CSR_GAP_LIMIT;
   logic [31:0] csr_write_data = '0;

   grds_req_if req_chan ();
   grds_rsp_if rsp_chan ();

   genomic_run_domain_segmenter_top uut (
      .clock(clock), .reset(reset), .csr_write_enable(csr_write_enable),
      .csr_index(csr_index), .csr_write_data(csr_write_data),
      .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source)
   );

   // Predictor state and configuration.
   logic [31:0] desert_gap;
   logic [2:0]  rep_setting;
   logic        seen_site;
   logic [15:0] last_chrom;
   logic [31:0] last_pos;
   logic        domain_open;
   logic [15:0] domain_chrom_q;
   logic [31:0] domain_start_q;
   logic [SITES_W-1:0] domain_sites_q;
   logic [SCORE_W-1:0] domain_score_q;
   logic [NUMBER_W-1:0] domain_index;

   result_type expected_domains [$];
   int error_count = 0;
   int idle_cycles = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_off = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int active_replicates();
      if (rep_setting < 1) return 1;
      if (rep_setting > MAXREP) return MAXREP;
      return rep_setting;
   endfunction

   function automatic void emit_domain();
      result_type r;
      r.domain_chrom = domain_chrom_q;
      r.start_position = domain_start_q;
      r.end_position = {1'b0, last_pos} + 33'd1;
      r.site_count = domain_sites_q;
      r.domain_score = domain_score_q;
      r.domain_number = domain_index;
      expected_domains.insert(expected_domains.size(), r);
      domain_index = domain_index + 1'b1;
      domain_open = 1'b0;
      domain_sites_q = '0;
      domain_score_q = '0;
   endfunction

   function automatic void predict_site(site_type s);
      logic [SCORE_W+1:0] site_sum;
      logic [SCORE_W+1:0] acc;
      logic [16:0] total;
      logic brk;
      site_sum = '0;
      if (s.eos) begin
         if (domain_open) emit_domain();
         seen_site = 1'b0;
         return;
      end
      for (int r = 0; r < active_replicates(); r++) begin
         total = {1'b0, s.meth[r]} + {1'b0, s.unmeth[r]};
         if (total == 0) return;
         site_sum += ({26'd0, s.unmeth[r]} << FRAC) / total;
      end
      brk = !seen_site || s.chrom != last_chrom || s.pos < last_pos
         || (s.pos - last_pos) > desert_gap;
      if (brk && domain_open) emit_domain();
      if (s.dom) begin
         if (!domain_open) begin
            domain_open = 1'b1;
            domain_chrom_q = s.chrom;
            domain_start_q = s.pos;
            domain_sites_q = '0;
            domain_score_q = '0;
         end
         if (domain_sites_q != SITES_SAT) domain_sites_q++;
         acc = {2'b0, domain_score_q} + site_sum;
         domain_score_q = (acc > SCORE_SAT) ? SCORE_SAT : acc[SCORE_W-1:0];
      end else if (domain_open) begin
         emit_domain();
      end
      seen_site = 1'b1;
      last_chrom = s.chrom;
      last_pos = s.pos;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
      error_count++;
   endtask

   // Receiver: random stalls, long hold-off when requested, and the result check.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off > 0) begin
            hold_off--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_domains.size() == 0) begin
            report_mismatch("unexpected domain beat", rsp_chan.domain_number, '0);
         end else begin
            result_type e;
            e = expected_domains.pop_front();
            if (rsp_chan.domain_chrom !== e.domain_chrom)
               report_mismatch("domain_chrom", rsp_chan.domain_chrom, e.domain_chrom);
            if (rsp_chan.start_position !== e.start_position)
               report_mismatch("start_position", rsp_chan.start_position, e.start_position);
            if (rsp_chan.end_position !== e.end_position)
               report_mismatch("end_position", rsp_chan.end_position, e.end_position);
            if (rsp_chan.site_count !== e.site_count)
               report_mismatch("site_count", rsp_chan.site_count, e.site_count);
            if (rsp_chan.domain_score !== e.domain_score)
               report_mismatch("domain_score", rsp_chan.domain_score, e.domain_score);
            if (rsp_chan.domain_number !== e.domain_number)
               report_mismatch("domain_number", rsp_chan.domain_number, e.domain_number);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL genomic_run_domain_segmenter_top");
         $finish;
      end
   end

   task automatic send_site(site_type s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.chrom_id <= s.chrom;
      req_chan.position <= s.pos;
      req_chan.domain_bit <= s.dom;
      req_chan.meth_count_0 <= s.meth[0];
      req_chan.unmeth_count_0 <= s.unmeth[0];
      req_chan.meth_count_1 <= s.meth[1];
      req_chan.unmeth_count_1 <= s.unmeth[1];
      req_chan.meth_count_2 <= s.meth[2];
      req_chan.unmeth_count_2 <= s.unmeth[2];
      req_chan.meth_count_3 <= s.meth[3];
      req_chan.unmeth_count_3 <= s.unmeth[3];
      req_chan.end_of_stream <= s.eos;
      do @(posedge clock); while (!req_chan.ready);
      predict_site(s);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      while (expected_domains.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [31:0] value);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_GAP_LIMIT) desert_gap = value;
      else rep_setting = value[2:0];
   endtask

   function automatic site_type make_site(logic [15:0] chrom, logic [31:0] pos, logic dom);
      site_type s;
      s.chrom = chrom;
      s.pos = pos;
      s.dom = dom;
      s.eos = 1'b0;
      for (int r = 0; r < 4; r++) begin
         s.meth[r] = $urandom_range(3) == 0 ? 16'hFFFF : 16'($urandom_range(200));
         s.unmeth[r] = $urandom_range(3) == 0 ? 16'hFFFF : 16'($urandom_range(200) + 1);
      end
      return s;
   endfunction

   function automatic site_type make_eos();
      site_type s;
      s = make_site(16'($urandom), $urandom, 1'($urandom));
      s.eos = 1'b1;
      return s;
   endfunction

   task automatic test_directed();
      site_type s;
      write_csr(CSR_REPLICATE_COUNT, 3'd4);
      write_csr(CSR_GAP_LIMIT, 32'd100);
      s = make_site(16'hFFFF, 32'hFFFF_FFF0, 1'b1);
      s.meth[0] = 16'd0; s.unmeth[0] = 16'hFFFF;
      s.meth[1] = 16'hFFFF; s.unmeth[1] = 16'd0;
      send_site(s);
      s = make_site(16'hFFFF, 32'hFFFF_FFFF, 1'b1);
      send_site(s);
      s = make_site(16'hFFFF, 32'hFFFF_FFFF, 1'b1);
      s.meth[3] = 16'd0; s.unmeth[3] = 16'd0;
      send_site(s);
      send_site(make_eos());
      send_site(make_eos());
      send_site(make_site(16'd0, 32'd0, 1'b1));
      send_site(make_site(16'd0, 32'd100, 1'b1));
      send_site(make_site(16'd0, 32'd201, 1'b1));
      send_site(make_site(16'd0, 32'd150, 1'b1));
      send_site(make_site(16'd1, 32'd150, 1'b1));
      send_site(make_site(16'd1, 32'd160, 1'b0));
      send_site(make_site(16'd1, 32'd170, 1'b0));
      send_site(make_site(16'd1, 32'd180, 1'b1));
      send_site(make_eos());
      write_csr(CSR_REPLICATE_COUNT, 3'd0);
      s = make_site(16'd2, 32'd5, 1'b1);
      s.meth[1] = 16'd0; s.unmeth[1] = 16'd0;
      send_site(s);
      write_csr(CSR_REPLICATE_COUNT, 3'd7);
      send_site(make_site(16'd2, 32'd6, 1'b1));
      write_csr(CSR_GAP_LIMIT, 32'hFFFF_FFFF);
      send_site(make_site(16'd2, 32'd0, 1'b1));
      send_site(make_site(16'd2, 32'hFFFF_FFFF, 1'b1));
      write_csr(CSR_GAP_LIMIT, 32'd0);
      send_site(make_site(16'd2, 32'hFFFF_FFFF, 1'b1));
      send_site(make_site(16'hA5A5, 32'h5A5A_5A5A, 1'b1));
      send_site(make_eos());
   endtask

   task automatic run_random(int count);
      site_type s;
      logic [15:0] chrom;
      logic [31:0] pos;
      chrom = 16'($urandom);
      pos = $urandom;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(19))
            0: s = make_eos();
            1: s = make_site(16'($urandom), $urandom, 1'($urandom));
            2: begin
               s = make_site(chrom, pos, 1'($urandom));
               s.meth[$urandom_range(3)] = 16'd0;
               s.unmeth[$urandom_range(3)] = 16'd0;
            end
            default: begin
               if ($urandom_range(9) == 0) chrom = 16'($urandom);
               pos = pos + ($urandom_range(9) == 0 ? desert_gap + 1 :
                  $urandom_range(desert_gap > 300 ? 300 : desert_gap));
               s = make_site(chrom, pos, $urandom_range(4) != 0);
            end
         endcase
         send_site(s);
      end
   endtask

   task automatic test_random_settings();
      write_csr(CSR_GAP_LIMIT, 32'd1000);
      for (int k = 1; k <= 4; k++) begin
         write_csr(CSR_REPLICATE_COUNT, 3'(k));
         write_csr(CSR_GAP_LIMIT, 32'($urandom_range(500)));
         run_random(230);
      end
   endtask

   task automatic test_backpressure();
      hold_off = 400;
      run_random(60);
      drain_results();
      run_random(40);
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.chrom_id = '0;
      req_chan.position = '0;
      req_chan.domain_bit = 1'b0;
      req_chan.meth_count_0 = '0;
      req_chan.unmeth_count_0 = '0;
      req_chan.meth_count_1 = '0;
      req_chan.unmeth_count_1 = '0;
      req_chan.meth_count_2 = '0;
      req_chan.unmeth_count_2 = '0;
      req_chan.meth_count_3 = '0;
      req_chan.unmeth_count_3 = '0;
      req_chan.end_of_stream = 1'b0;
      desert_gap = 32'd1000;
      rep_setting = 3'd1;
      seen_site = 1'b0;
      last_chrom = '0;
      last_pos = '0;
      domain_open = 1'b0;
      domain_chrom_q = '0;
      domain_start_q = '0;
      domain_sites_q = '0;
      domain_score_q = '0;
      domain_index = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      send_idle_pct = 7; recv_idle_pct = 84;
      test_random_settings();
      send_idle_pct = 84; recv_idle_pct = 7;
      test_random_settings();
      send_idle_pct = 0; recv_idle_pct = 0;
      test_backpressure();
      drain_results();
      if (error_count == 0)
         $display("PASS genomic_run_domain_segmenter_top");
      else
         $display("FAIL genomic_run_domain_segmenter_top");
      $finish;
   end

endmodule
